/* sv/bfbrp_pkg.sv */
// bfbrp_pkg: shared types and constants of the buffer recycle pool.
// Used by bfbrp_ram and best_fit_buffer_recycle_pool; no dependencies.
package bfbrp_pkg;

  localparam int POOL_DEPTH = 8;
  localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

  localparam int HANDLE_W    = 16;
  localparam int SIZE_W      = 32;
  localparam int PC_W        = 4;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef logic [IDX_W-1:0] slot_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  typedef struct packed {
    logic   we;
    slot_t  waddr;
    entry_t wdata;
  } ram_wr_t;

  typedef struct packed {
    logic  re;
    slot_t raddr;
  } ram_rd_t;

endpackage

/* sv/bfbrp_ram.sv */
// bfbrp_ram: entry store of the pool, one write and one read port,
// registered read data. Depends on bfbrp_pkg.
module bfbrp_ram (
  input  logic                clk,
  input  bfbrp_pkg::ram_wr_t  wr,
  input  bfbrp_pkg::ram_rd_t  rd,
  output bfbrp_pkg::entry_t   rdata
);

  bfbrp_pkg::entry_t mem [bfbrp_pkg::POOL_DEPTH];
  bfbrp_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
    if (rd.re) begin
      rdata_r <= mem[rd.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/best_fit_buffer_recycle_pool.sv */
// best_fit_buffer_recycle_pool: best-fit free list with oldest-first eviction.
// Depends on bfbrp_pkg and bfbrp_ram.
// Release: IDLE, then FIN loads the output; into a full pool REL_EV (eviction) comes between.
// Allocation: a scan (one entry read a cycle from the entry RAM), then on a hit
// a compaction that moves each later entry one position forward to close the gap.
// One item at a time; the next item is taken while a result waits in the
// output register. Reset (rst_n low, synchronous) empties the pool; the
// entry RAM itself is not cleared and needs no pass.
module best_fit_buffer_recycle_pool (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [31:0] request_size, [47:32] returned_handle, [79:48] returned_size
  input  logic [bfbrp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] operation
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] given_handle, [47:16] given_size, [63:48] evicted_handle,
  // [67:64] pool_count, [71:68] zero
  output logic [bfbrp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] found, [1] evicted
  output logic [bfbrp_pkg::OUT_TUSER_W-1:0]    out_tuser
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL_EV,
    ST_SCAN,
    ST_COMP,
    ST_FIN
  } state_t;

  state_t state_r;

  // ring position state
  bfbrp_pkg::slot_t front_r;
  bfbrp_pkg::cnt_t  count_r;

  // latched request
  logic [bfbrp_pkg::SIZE_W-1:0]   req_r;
  logic [bfbrp_pkg::HANDLE_W-1:0] rh_r;
  logic [bfbrp_pkg::SIZE_W-1:0]   rs_r;

  // scan / compaction pointers
  bfbrp_pkg::cnt_t rd_pos_r;   // next position to read
  bfbrp_pkg::cnt_t cmp_pos_r;  // position of data now on rdata (scan)
  bfbrp_pkg::cnt_t wr_pos_r;   // next position to fill (compaction)
  logic            pend_r;     // rdata holds a fresh read

  // best candidate so far
  logic                           have_r;
  bfbrp_pkg::cnt_t                best_pos_r;
  logic [bfbrp_pkg::HANDLE_W-1:0] best_handle_r;
  logic [bfbrp_pkg::SIZE_W-1:0]   best_size_r;

  // result fields
  logic                           res_found_r;
  logic [bfbrp_pkg::HANDLE_W-1:0] res_handle_r;
  logic [bfbrp_pkg::SIZE_W-1:0]   res_size_r;
  logic                           res_ev_r;
  logic [bfbrp_pkg::HANDLE_W-1:0] res_evh_r;

  // output register
  logic                                out_valid_r;
  logic [bfbrp_pkg::OUT_TDATA_W-1:0]   out_tdata_r;
  logic [bfbrp_pkg::OUT_TUSER_W-1:0]   out_tuser_r;

  bfbrp_pkg::ram_wr_t mem_wr;
  bfbrp_pkg::ram_rd_t mem_rd;
  bfbrp_pkg::entry_t  mem_rdata;

  // input fields
  logic                           in_op;
  logic [bfbrp_pkg::SIZE_W-1:0]   in_req;
  logic [bfbrp_pkg::HANDLE_W-1:0] in_rh;
  logic [bfbrp_pkg::SIZE_W-1:0]   in_rs;
  logic                           in_acc;

  assign in_op  = in_tuser;
  assign in_req = in_tdata[31:0];
  assign in_rh  = in_tdata[47:32];
  assign in_rs  = in_tdata[79:48];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // ring slot of position pos: front + pos, wrapped once
  function automatic bfbrp_pkg::slot_t slot_of(bfbrp_pkg::slot_t front,
                                               bfbrp_pkg::cnt_t pos);
    logic [bfbrp_pkg::CNT_W:0] sum;
    sum = (bfbrp_pkg::CNT_W+1)'(front) + (bfbrp_pkg::CNT_W+1)'(pos);
    if (sum >= (bfbrp_pkg::CNT_W+1)'(bfbrp_pkg::POOL_DEPTH)) begin
      sum = sum - (bfbrp_pkg::CNT_W+1)'(bfbrp_pkg::POOL_DEPTH);
    end
    return bfbrp_pkg::slot_t'(sum);
  endfunction

  bfbrp_pkg::slot_t new_front;
  logic             pool_full;
  logic             rd_more;
  logic             scan_exact;
  logic             scan_fit;
  logic             scan_better;
  logic             out_free;

  // pushing goes one slot back; when full that is also the oldest slot
  assign new_front = (front_r == '0) ? bfbrp_pkg::slot_t'(bfbrp_pkg::POOL_DEPTH - 1)
                                     : front_r - 1'b1;
  assign pool_full = (count_r == bfbrp_pkg::cnt_t'(bfbrp_pkg::POOL_DEPTH));
  assign rd_more   = (rd_pos_r < count_r);

  assign scan_exact  = pend_r && (mem_rdata.size == req_r);
  assign scan_fit    = pend_r && (mem_rdata.size > req_r) &&
                       (req_r > (mem_rdata.size >> 1));
  assign scan_better = scan_fit && (!have_r || (best_size_r > mem_rdata.size));
  assign out_free    = !out_valid_r || out_tready;

  // RAM port control
  always_comb begin
    mem_wr = '0;
    mem_rd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == bfbrp_pkg::OP_RELEASE) && (in_rh != '0)) begin
          if (pool_full) begin
            // fetch the oldest entry for the eviction report
            mem_rd.re    = 1'b1;
            mem_rd.raddr = new_front;
          end else begin
            mem_wr.we          = 1'b1;
            mem_wr.waddr       = new_front;
            mem_wr.wdata.handle = in_rh;
            mem_wr.wdata.size   = in_rs;
          end
        end
      end
      ST_REL_EV: begin
        mem_wr.we           = 1'b1;
        mem_wr.waddr        = new_front;
        mem_wr.wdata.handle = rh_r;
        mem_wr.wdata.size   = rs_r;
      end
      ST_SCAN: begin
        mem_rd.re    = !scan_exact && rd_more;
        mem_rd.raddr = slot_of(front_r, rd_pos_r);
      end
      ST_COMP: begin
        // move position k+1 into position k, one read ahead of the write
        mem_rd.re    = rd_more;
        mem_rd.raddr = slot_of(front_r, rd_pos_r);
        mem_wr.we    = pend_r;
        mem_wr.waddr = slot_of(front_r, wr_pos_r);
        mem_wr.wdata = mem_rdata;
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  bfbrp_ram u_ram (
    .clk   (clk),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in FIN the register is reloaded instead
      if (out_valid_r && out_tready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            req_r        <= in_req;
            rh_r         <= in_rh;
            rs_r         <= in_rs;
            res_found_r  <= 1'b0;
            res_handle_r <= '0;
            res_size_r   <= '0;
            res_ev_r     <= 1'b0;
            res_evh_r    <= '0;
            have_r       <= 1'b0;
            pend_r       <= 1'b0;
            rd_pos_r     <= '0;
            if (in_op == bfbrp_pkg::OP_RELEASE) begin
              if (in_rh == '0) begin
                state_r <= ST_FIN;
              end else if (pool_full) begin
                state_r <= ST_REL_EV;
              end else begin
                front_r <= new_front;
                count_r <= count_r + 1'b1;
                state_r <= ST_FIN;
              end
            end else if (count_r == '0) begin
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end

        ST_REL_EV: begin
          // count stays at full: one out, one in
          res_ev_r  <= 1'b1;
          res_evh_r <= mem_rdata.handle;
          front_r   <= new_front;
          state_r   <= ST_FIN;
        end

        ST_SCAN: begin
          if (scan_exact) begin
            res_found_r  <= 1'b1;
            res_handle_r <= mem_rdata.handle;
            res_size_r   <= mem_rdata.size;
            rd_pos_r     <= cmp_pos_r + 1'b1;
            wr_pos_r     <= cmp_pos_r;
            pend_r       <= 1'b0;
            state_r      <= ST_COMP;
          end else begin
            if (scan_better) begin
              have_r        <= 1'b1;
              best_pos_r    <= cmp_pos_r;
              best_handle_r <= mem_rdata.handle;
              best_size_r   <= mem_rdata.size;
            end
            pend_r    <= rd_more;
            cmp_pos_r <= rd_pos_r;
            if (rd_more) begin
              rd_pos_r <= rd_pos_r + 1'b1;
            end else if (!pend_r) begin
              if (have_r) begin
                res_found_r  <= 1'b1;
                res_handle_r <= best_handle_r;
                res_size_r   <= best_size_r;
                rd_pos_r     <= best_pos_r + 1'b1;
                wr_pos_r     <= best_pos_r;
                state_r      <= ST_COMP;
              end else begin
                state_r <= ST_FIN;  // miss, pool untouched
              end
            end
          end
        end

        ST_COMP: begin
          if (pend_r) begin
            wr_pos_r <= wr_pos_r + 1'b1;
          end
          if (rd_more) begin
            rd_pos_r <= rd_pos_r + 1'b1;
          end
          pend_r <= rd_more;
          if (!pend_r && !rd_more) begin
            count_r <= count_r - 1'b1;
            state_r <= ST_FIN;
          end
        end

        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_tuser_r <= {res_ev_r, res_found_r};
            out_tdata_r <= {4'b0000, bfbrp_pkg::PC_W'(count_r), res_evh_r,
                            res_size_r, res_handle_r};
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // pool never holds more than its depth, front stays inside the ring
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bfbrp_pkg::cnt_t'(bfbrp_pkg::POOL_DEPTH))
    else $error("pool count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= bfbrp_pkg::slot_t'(bfbrp_pkg::POOL_DEPTH - 1))
    else $error("ring front out of range");

  // a release into a pool with room grows it by one
  a_release_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == bfbrp_pkg::OP_RELEASE) && (in_rh != '0) && !pool_full
    |=> count_r == $past(count_r) + 1'b1)
    else $error("release did not add an entry");

  // the scan only reads; the entry store is not written meanwhile
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !mem_wr.we)
    else $error("entry write during scan");

  // a removal ends with one entry less
  a_comp_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP) && !pend_r && !rd_more
    |=> count_r == $past(count_r) - 1'b1)
    else $error("removal did not drop an entry");

endmodule
